// ----- hdl/r45_pkg.sv -----
// Shared types, widths, cut tables and table lookup functions for the R45 noise check.
// Used by r45_div, r45_cut and r45_pulse_shape_noise_check_unit.
// Has no dependencies of its own.
`timescale 1ns / 1ps

package r45_pkg;

   // Fixed-point formats of the charges and of the ratio.
   localparam int CHARGE_FRAC_BITS = 4;
   localparam int RATIO_FRAC_BITS  = 16;

   // Field widths.
   localparam int CHG_W     = 21;
   localparam int SUM_W     = 22;
   localparam int RATIO_W   = RATIO_FRAC_BITS + 5;
   localparam int MIN_SUM_W = 20;
   localparam logic [MIN_SUM_W-1:0] MIN_SUM_RESET = MIN_SUM_W'(16);

   // Divider geometry: the quotient magnitude has as many bits as the ratio field.
   localparam int DMAG_W     = SUM_W - 1;
   localparam int PMAG_W     = SUM_W;
   localparam int QW         = RATIO_W;
   localparam int SH         = QW - RATIO_FRAC_BITS;
   localparam int REM_W      = PMAG_W;
   localparam int DIV_BPS    = 3;
   localparam int DIV_STAGES = (QW + DIV_BPS - 1) / DIV_BPS;

   // Cut interpolation geometry.
   localparam int CUT_STAGES = 4;
   localparam int TBL_N      = 8;
   localparam int IDX_W      = $clog2(TBL_N);
   localparam int LEN_W      = $clog2(TBL_N + 1);
   localparam int THR_W      = 13;
   localparam int CUT_W      = 8;
   localparam int THR16_W    = THR_W + CHARGE_FRAC_BITS;
   localparam int HUNDRED_W  = 7;
   localparam int A_W        = THR_W + HUNDRED_W + CHARGE_FRAC_BITS;
   localparam int B_W        = THR_W + CHARGE_FRAC_BITS + CUT_W + 2;
   localparam int PROD_W     = SUM_W + B_W;

   // Cuts are held in hundredths.
   localparam logic [HUNDRED_W-1:0] CUT_SCALE = HUNDRED_W'(100);

   typedef enum logic [1:0] {
      TBL_UPPER,
      TBL_CHAN,
      TBL_BOX
   } tbl_id_type;

   typedef enum logic [1:0] {
      HIT_NONE,
      HIT_LOWER,
      HIT_UPPER,
      HIT_INFINITE
   } hit_type;

   // Outcome of one cut comparison.
   typedef struct packed {
      logic below;
      logic above;
   } cut_res_type;

   // Threshold tables in fC; unused tail entries repeat the last threshold.
   localparam logic [THR_W-1:0] UP_THR [TBL_N] = '{
      THR_W'(70), THR_W'(90), THR_W'(100), THR_W'(400),
      THR_W'(4000), THR_W'(4000), THR_W'(4000), THR_W'(4000)};
   localparam logic signed [CUT_W-1:0] UP_CUT [TBL_N] = '{
      CUT_W'(100), CUT_W'(80), CUT_W'(75), CUT_W'(72),
      CUT_W'(72), CUT_W'(72), CUT_W'(72), CUT_W'(72)};
   localparam logic [THR_W-1:0] CH_THR [TBL_N] = '{
      THR_W'(100), THR_W'(120), THR_W'(160), THR_W'(200),
      THR_W'(300), THR_W'(500), THR_W'(4000), THR_W'(4000)};
   localparam logic signed [CUT_W-1:0] CH_CUT [TBL_N] = '{
      -CUT_W'(100), -CUT_W'(70), -CUT_W'(50), -CUT_W'(40),
      -CUT_W'(30), CUT_W'(10), CUT_W'(10), CUT_W'(10)};
   localparam logic [THR_W-1:0] BX_THR [TBL_N] = '{
      THR_W'(100), THR_W'(120), THR_W'(150), THR_W'(200),
      THR_W'(300), THR_W'(400), THR_W'(500), THR_W'(4000)};
   localparam logic signed [CUT_W-1:0] BX_CUT [TBL_N] = '{
      -CUT_W'(100), -CUT_W'(70), -CUT_W'(40), -CUT_W'(20),
      -CUT_W'(8), CUT_W'(0), CUT_W'(10), CUT_W'(10)};

   function automatic logic [LEN_W-1:0] tbl_len(input tbl_id_type id);
      logic [LEN_W-1:0] n;
      case (id)
         TBL_UPPER: n = LEN_W'(5);
         TBL_CHAN:  n = LEN_W'(7);
         TBL_BOX:   n = LEN_W'(8);
         default:   n = LEN_W'(5);
      endcase
      return n;
   endfunction

   function automatic logic [THR_W-1:0] tbl_thr(input tbl_id_type id,
                                               input logic [IDX_W-1:0] idx);
      logic [THR_W-1:0] v;
      case (id)
         TBL_UPPER: v = UP_THR[idx];
         TBL_CHAN:  v = CH_THR[idx];
         TBL_BOX:   v = BX_THR[idx];
         default:   v = UP_THR[idx];
      endcase
      return v;
   endfunction

   function automatic logic signed [CUT_W-1:0] tbl_cut(input tbl_id_type id,
                                                      input logic [IDX_W-1:0] idx);
      logic signed [CUT_W-1:0] v;
      case (id)
         TBL_UPPER: v = UP_CUT[idx];
         TBL_CHAN:  v = CH_CUT[idx];
         TBL_BOX:   v = BX_CUT[idx];
         default:   v = UP_CUT[idx];
      endcase
      return v;
   endfunction

endpackage

// ----- hdl/r45_div.sv -----
// Pipelined restoring divider giving the magnitude of the R45 quotient.
// Depends on r45_pkg for the quotient width and the number of bits per stage.
`timescale 1ns / 1ps

module r45_div
   import r45_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [DMAG_W-1:0] dmag,
   input  logic [PMAG_W-1:0] pmag,
   output logic [QW-1:0]     q_mag,
   output logic              sat
);

   logic [REM_W-1:0]  rem_ff [DIV_STAGES];
   logic [REM_W-1:0]  rem_in [DIV_STAGES];
   logic [QW-1:0]     nlo_ff [DIV_STAGES];
   logic [QW-1:0]     nlo_in [DIV_STAGES];
   logic [QW-1:0]     q_ff   [DIV_STAGES];
   logic [QW-1:0]     q_in   [DIV_STAGES];
   logic [PMAG_W-1:0] dvs_ff [DIV_STAGES];
   logic [PMAG_W-1:0] dvs_in [DIV_STAGES];
   logic              sat_ff [DIV_STAGES];
   logic              sat_in [DIV_STAGES];

   logic [REM_W-1:0]  rem_src [DIV_STAGES];
   logic [QW-1:0]     nlo_src [DIV_STAGES];
   logic [QW-1:0]     q_src   [DIV_STAGES];
   logic [PMAG_W-1:0] dvs_src [DIV_STAGES];
   logic              sat_src [DIV_STAGES];

   // The first stage checks for overflow: a quotient that needs more bits
   // than the field saturates. Otherwise the top of the numerator is already
   // below the divisor and the low bits are brought in one per step.
   assign rem_src[0] = REM_W'(dmag >> SH);
   assign nlo_src[0] = {dmag[SH-1:0], {RATIO_FRAC_BITS{1'b0}}};
   assign q_src[0]   = '0;
   assign dvs_src[0] = pmag;
   assign sat_src[0] = (PMAG_W + SH)'(dmag) >= {pmag, {SH{1'b0}}};

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      if (s > 0) begin : g_link
         assign rem_src[s] = rem_ff[s-1];
         assign nlo_src[s] = nlo_ff[s-1];
         assign q_src[s]   = q_ff[s-1];
         assign dvs_src[s] = dvs_ff[s-1];
         assign sat_src[s] = sat_ff[s-1];
      end

      // DIV_BPS shift-and-subtract steps per stage.
      always_comb begin
         logic [REM_W:0]   t;
         logic [REM_W-1:0] r;
         logic [QW-1:0]    n;
         logic [QW-1:0]    q;
         r = rem_src[s];
         n = nlo_src[s];
         q = q_src[s];
         t = '0;
         for (int j = 0; j < DIV_BPS; j++) begin
            if (s * DIV_BPS + j < QW) begin
               t = {r, n[QW-1]};
               n = {n[QW-2:0], 1'b0};
               if (t >= (REM_W + 1)'(dvs_src[s])) begin
                  r = REM_W'(t - (REM_W + 1)'(dvs_src[s]));
                  q = {q[QW-2:0], 1'b1};
               end else begin
                  r = t[REM_W-1:0];
                  q = {q[QW-2:0], 1'b0};
               end
            end
         end
         rem_in[s] = r;
         nlo_in[s] = n;
         q_in[s]   = q;
         dvs_in[s] = dvs_src[s];
         sat_in[s] = sat_src[s];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in[s];
            nlo_ff[s] <= nlo_in[s];
            q_ff[s]   <= q_in[s];
            dvs_ff[s] <= dvs_in[s];
            sat_ff[s] <= sat_in[s];
         end
      end
   end

   assign q_mag = q_ff[DIV_STAGES-1];
   assign sat   = sat_ff[DIV_STAGES-1];

endmodule

// ----- hdl/r45_cut.sv -----
// Four-stage cut evaluation: bin search, interpolation terms, cross products, compare.
// Depends on r45_pkg for the threshold tables and the widths.
`timescale 1ns / 1ps

module r45_cut
   import r45_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  tbl_id_type         id,
   input  logic signed [SUM_W-1:0] p,
   input  logic signed [SUM_W-1:0] d,
   output cut_res_type        res
);

   logic                    on_a_ff,  on_a_in;
   logic signed [SUM_W-1:0] p_a_ff, d_a_ff;
   logic [THR_W-1:0]        thr_b_ff, thr_b_in, thr_n_ff, thr_n_in, last_ff, last_in;
   logic signed [CUT_W-1:0] cut_b_ff, cut_b_in, cut_n_ff, cut_n_in;

   logic                    on_b_ff;
   logic signed [SUM_W-1:0] p_b_ff, d_b_ff;
   logic [A_W-1:0]          a_b_ff, a_b_in;
   logic signed [B_W-1:0]   b_b_ff, b_b_in;

   logic                     on_c_ff;
   logic signed [PROD_W-1:0] lhs_ff, lhs_in, rhs_ff, rhs_in;

   cut_res_type res_ff, res_in;

   // Bin search: the last threshold strictly below the sum, the last entry excluded.
   always_comb begin
      logic [LEN_W-1:0]   n;
      logic [IDX_W-1:0]   bin;
      logic [THR16_W-1:0] t16;
      n   = tbl_len(id);
      bin = '0;
      on_a_in = 1'b0;
      for (int j = 0; j < TBL_N - 1; j++) begin
         t16 = {tbl_thr(id, IDX_W'(j)), {CHARGE_FRAC_BITS{1'b0}}};
         if ((LEN_W'(j) < n - LEN_W'(1)) && (p > $signed(SUM_W'(t16)))) begin
            bin = IDX_W'(j);
            on_a_in = 1'b1;
         end
      end
      thr_b_in = tbl_thr(id, bin);
      thr_n_in = tbl_thr(id, bin + IDX_W'(1));
      cut_b_in = tbl_cut(id, bin);
      cut_n_in = tbl_cut(id, bin + IDX_W'(1));
      last_in  = tbl_thr(id, IDX_W'(n - LEN_W'(1)));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         on_a_ff  <= on_a_in;
         p_a_ff   <= p;
         d_a_ff   <= d;
         thr_b_ff <= thr_b_in;
         thr_n_ff <= thr_n_in;
         cut_b_ff <= cut_b_in;
         cut_n_ff <= cut_n_in;
         last_ff  <= last_in;
      end
   end

   // Interpolation terms: the ratio test becomes d*A against p*B.
   always_comb begin
      logic [THR16_W-1:0]      last16, thrb16, pc, off;
      logic [THR_W-1:0]        dt;
      logic signed [CUT_W:0]   dc;
      logic signed [B_W-1:0]   b1, b2;
      last16 = {last_ff, {CHARGE_FRAC_BITS{1'b0}}};
      thrb16 = {thr_b_ff, {CHARGE_FRAC_BITS{1'b0}}};
      pc     = (p_a_ff > $signed(SUM_W'(last16))) ? last16 : p_a_ff[THR16_W-1:0];
      off    = pc - thrb16;
      dt     = thr_n_ff - thr_b_ff;
      dc     = (CUT_W + 1)'(cut_n_ff) - (CUT_W + 1)'(cut_b_ff);
      a_b_in = A_W'(dt * CUT_SCALE) << CHARGE_FRAC_BITS;
      b1     = (B_W'(cut_b_ff) * B_W'($signed({1'b0, dt}))) <<< CHARGE_FRAC_BITS;
      b2     = B_W'($signed({1'b0, off})) * B_W'(dc);
      b_b_in = b1 + b2;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         on_b_ff <= on_a_ff;
         p_b_ff  <= p_a_ff;
         d_b_ff  <= d_a_ff;
         a_b_ff  <= a_b_in;
         b_b_ff  <= b_b_in;
      end
   end

   // Cross products.
   assign lhs_in = PROD_W'(d_b_ff) * PROD_W'($signed({1'b0, a_b_ff}));
   assign rhs_in = PROD_W'(p_b_ff) * PROD_W'(b_b_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         on_c_ff <= on_b_ff;
         lhs_ff  <= lhs_in;
         rhs_ff  <= rhs_in;
      end
   end

   // Compare; a disabled cut never fires.
   assign res_in.below = on_c_ff && (lhs_ff < rhs_ff);
   assign res_in.above = on_c_ff && (lhs_ff > rhs_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ----- hdl/r45_pulse_shape_noise_check_unit.sv -----
// Top level of the R45 pulse-shape noise check.
// Depends on r45_pkg, r45_div and r45_cut.
`timescale 1ns / 1ps

// Usage
// The req channel carries one channel per transaction: tdata holds the two
// time-slice charges, tuser the mode (0 per channel, 1 per box). The rsp
// channel returns one transaction per request with the ratio, the sum used,
// the not-positive flag, and in tuser the noisy flag and the limit code.
// The csr port writes the box-mode sum floor; write it only while idle.
// Throughput is one transaction per cycle while the receiver keeps up. A result
// passes the input register, the pipelined divider, which resolves three
// quotient bits per stage, and the output register; the cut path runs alongside
// the divider in four stages and is delayed to match.
// When the receiver stalls, the whole pipeline holds and req_tready drops;
// nothing is lost or repeated. Reset clears all valid flags and sets the
// sum floor to 1 fC.

module r45_pulse_shape_noise_check_unit
   import r45_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [47:0]          req_tdata,  // charge_ts4[20:0], charge_ts5[41:21], zero
   input  logic [0:0]           req_tuser,  // action[0]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [47:0]          rsp_tdata,  // ratio[20:0], sum_used[42:21],
                                            // sum_not_positive[43], zero
   output logic [2:0]           rsp_tuser,  // noisy[0], limit_hit[2:1]
   input  logic                 csr_we,
   input  logic [MIN_SUM_W-1:0] csr_wdata
);

   localparam int CUT_DLY = DIV_STAGES - CUT_STAGES;

   typedef struct packed {
      logic signed [SUM_W-1:0] p;
      logic                    qneg;
      logic                    pzero;
      logic                    ppos;
      logic                    dpos;
      logic                    dzero;
   } side_type;

   logic [MIN_SUM_W-1:0] min_sum_ff;
   logic                 en;

   logic                    v1_ff;
   logic                    box_ff;
   logic signed [SUM_W-1:0] p1_ff, p1_in, d1_ff, d1_in;
   logic [DMAG_W-1:0]       dmag_ff, dmag_in;
   logic [PMAG_W-1:0]       pmag_ff, pmag_in;
   side_type                side1_in;

   logic        vld_ff  [DIV_STAGES];
   side_type    side_ff [DIV_STAGES];
   cut_res_type cut_dly_ff [CUT_DLY];
   cut_res_type cut_res;
   logic [QW-1:0] q_mag;
   logic          sat;
   tbl_id_type    lo_id;
   cut_res_type   lo_res, up_res;

   logic                    out_valid_ff;
   logic                    noisy_ff, noisy_in;
   hit_type                 hit_ff, hit_in;
   logic [RATIO_W-1:0]      ratio_ff, ratio_in;
   logic signed [SUM_W-1:0] sum_ff;
   logic                    snp_ff;

   // The pipeline advances whenever the output register is free or being taken.
   assign en         = !out_valid_ff || rsp_tready;
   assign req_tready = en;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_sum_ff <= MIN_SUM_RESET;
      end else if (csr_we) begin
         min_sum_ff <= csr_wdata;
      end
   end

   // Stage one: sum, difference, floor and magnitudes.
   always_comb begin
      logic signed [CHG_W-1:0] c4, c5;
      logic signed [SUM_W-1:0] sum;
      c4    = req_tdata[CHG_W-1:0];
      c5    = req_tdata[2*CHG_W-1:CHG_W];
      sum   = SUM_W'(c4) + SUM_W'(c5);
      d1_in = SUM_W'(c4) - SUM_W'(c5);
      if (req_tuser[0] && (sum < $signed(SUM_W'(min_sum_ff)))) begin
         p1_in = $signed(SUM_W'(min_sum_ff));
      end else begin
         p1_in = sum;
      end
      dmag_in = d1_in[SUM_W-1] ? DMAG_W'(-d1_in) : DMAG_W'(d1_in);
      pmag_in = p1_in[SUM_W-1] ? PMAG_W'(-p1_in) : PMAG_W'(p1_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         box_ff  <= req_tuser[0];
         p1_ff   <= p1_in;
         d1_ff   <= d1_in;
         dmag_ff <= dmag_in;
         pmag_ff <= pmag_in;
      end
   end

   assign side1_in.p     = p1_ff;
   assign side1_in.qneg  = d1_ff[SUM_W-1] ^ p1_ff[SUM_W-1];
   assign side1_in.pzero = (p1_ff == '0);
   assign side1_in.ppos  = !p1_ff[SUM_W-1] && (p1_ff != '0);
   assign side1_in.dpos  = !d1_ff[SUM_W-1] && (d1_ff != '0);
   assign side1_in.dzero = (d1_ff == '0);

   // Quotient magnitude.
   r45_div u_div (
      .clock (clock),
      .en    (en),
      .dmag  (dmag_ff),
      .pmag  (pmag_ff),
      .q_mag (q_mag),
      .sat   (sat)
   );

   // Lower cut by mode, upper cut shared.
   assign lo_id = box_ff ? TBL_BOX : TBL_CHAN;

   r45_cut u_cut_lo (
      .clock (clock),
      .en    (en),
      .id    (lo_id),
      .p     (p1_ff),
      .d     (d1_ff),
      .res   (lo_res)
   );

   r45_cut u_cut_up (
      .clock (clock),
      .en    (en),
      .id    (TBL_UPPER),
      .p     (p1_ff),
      .d     (d1_ff),
      .res   (up_res)
   );

   // Valid flags and side data travel beside the divider stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= v1_ff;
         for (int i = 1; i < DIV_STAGES; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side1_in;
         for (int i = 1; i < DIV_STAGES; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         cut_dly_ff[0].below <= lo_res.below;
         cut_dly_ff[0].above <= up_res.above;
         for (int i = 1; i < CUT_DLY; i++) begin
            cut_dly_ff[i] <= cut_dly_ff[i-1];
         end
      end
   end

   assign cut_res = cut_dly_ff[CUT_DLY-1];

   // Final result: saturation, sign, and the noise decision.
   always_comb begin
      side_type s;
      s = side_ff[DIV_STAGES-1];
      if (s.pzero) begin
         ratio_in = s.dpos ? {1'b0, {(QW-1){1'b1}}} :
                    (s.dzero ? '0 : {1'b1, {(QW-1){1'b0}}});
      end else if (!s.qneg) begin
         ratio_in = (sat || q_mag[QW-1]) ? {1'b0, {(QW-1){1'b1}}} : q_mag;
      end else begin
         ratio_in = (sat || (q_mag[QW-1] && (|q_mag[QW-2:0]))) ?
                    {1'b1, {(QW-1){1'b0}}} : RATIO_W'(-q_mag);
      end
      noisy_in = 1'b0;
      hit_in   = HIT_NONE;
      if (s.pzero) begin
         if (!s.dzero) begin
            noisy_in = 1'b1;
            hit_in   = HIT_INFINITE;
         end
      end else if (s.ppos) begin
         if (cut_res.below) begin
            noisy_in = 1'b1;
            hit_in   = HIT_LOWER;
         end else if (cut_res.above) begin
            noisy_in = 1'b1;
            hit_in   = HIT_UPPER;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= vld_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         noisy_ff <= noisy_in;
         hit_ff   <= hit_in;
         ratio_ff <= ratio_in;
         sum_ff   <= side_ff[DIV_STAGES-1].p;
         snp_ff   <= !side_ff[DIV_STAGES-1].ppos;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(48 - RATIO_W - SUM_W - 1){1'b0}}, snp_ff, sum_ff, ratio_ff};
   assign rsp_tuser  = {hit_ff, noisy_ff};

   // The noisy flag and the limit code always agree.
   a_noisy_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (noisy_ff == (hit_ff != HIT_NONE)))
      else $error("noisy flag and limit code disagree");

   // An infinite ratio only comes from a zero sum.
   a_inf_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (hit_ff == HIT_INFINITE) |-> (sum_ff == '0))
      else $error("infinite ratio with a non-zero sum");

   // A cut only fires on a positive sum.
   a_cut_pos: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && ((hit_ff == HIT_LOWER) || (hit_ff == HIT_UPPER)) |-> !snp_ff)
      else $error("cut fired on a sum that is not positive");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !out_valid_ff)
      else $error("result pending right after reset");

endmodule

// ----- tb/tb_r45_pulse_shape_noise_check_unit.sv -----
// Testbench for the R45 pulse-shape noise check: drives charge pairs in bursts,
// predicts ratio, sum and noise flags in a scoreboard class and checks every result.
// Depends on r45_pkg and r45_pulse_shape_noise_check_unit.
`timescale 1ns / 1ps

module tb_r45_pulse_shape_noise_check_unit;
   import r45_pkg::*;

   typedef struct packed {
      logic       noisy;
      logic [1:0] hit;
      logic [20:0] ratio;
      logic [21:0] sum;
      logic       not_pos;
   } r45_result_type;

   // Threshold tables in fC and cuts in hundredths.
   localparam int UPT [5] = '{70, 90, 100, 400, 4000};
   localparam int UPC [5] = '{100, 80, 75, 72, 72};
   localparam int CHT [7] = '{100, 120, 160, 200, 300, 500, 4000};
   localparam int CHC [7] = '{-100, -70, -50, -40, -30, 10, 10};
   localparam int BXT [8] = '{100, 120, 150, 200, 300, 400, 500, 4000};
   localparam int BXC [8] = '{-100, -70, -40, -20, -8, 0, 10, 10};

   // Returns 0 when the cut is disabled, else 1 below, 2 equal, 3 above.
   function automatic int cut_compare(input int sel, input longint p, input longint d);
      int n, bin, t0, t1, k0, k1;
      longint pc, lhs, rhs;
      n = (sel == 0) ? 5 : (sel == 1) ? 7 : 8;
      bin = -1;
      for (int j = 0; j < n - 1; j++) begin
         t0 = (sel == 0) ? UPT[j] : (sel == 1) ? CHT[j] : BXT[j];
         if (longint'(t0) * 16 < p) bin = j;
      end
      if (bin < 0) return 0;
      t0 = (sel == 0) ? UPT[bin] : (sel == 1) ? CHT[bin] : BXT[bin];
      t1 = (sel == 0) ? UPT[bin+1] : (sel == 1) ? CHT[bin+1] : BXT[bin+1];
      k0 = (sel == 0) ? UPC[bin] : (sel == 1) ? CHC[bin] : BXC[bin];
      k1 = (sel == 0) ? UPC[bin+1] : (sel == 1) ? CHC[bin+1] : BXC[bin+1];
      pc = (p > 4000 * 16) ? 4000 * 16 : p;
      lhs = d * 100 * (t1 - t0) * 16;
      rhs = p * (longint'(k0) * (t1 - t0) * 16 + (pc - t0 * 16) * (k1 - k0));
      if (lhs > rhs) return 3;
      if (lhs < rhs) return 1;
      return 2;
   endfunction

   class r45_scoreboard;
      r45_result_type pending[$];
      logic [19:0] floor_val = 20'd16;
      int errors = 0;
      int checked = 0;

      function void note_request(logic box, logic signed [20:0] c4, logic signed [20:0] c5);
         longint p, d, q;
         int lo, up;
         r45_result_type r;
         p = longint'(c4) + longint'(c5);
         d = longint'(c4) - longint'(c5);
         if (box && p < longint'(floor_val)) p = longint'(floor_val);
         r = '0;
         if (p == 0) begin
            q = (d > 0) ? 1048575 : (d < 0) ? -1048576 : 0;
            if (d != 0) begin
               r.noisy = 1'b1;
               r.hit = HIT_INFINITE;
            end
         end else begin
            q = (d * 65536) / p;
            if (q > 1048575) q = 1048575;
            if (q < -1048576) q = -1048576;
            if (p > 0) begin
               lo = cut_compare(box ? 2 : 1, p, d);
               up = cut_compare(0, p, d);
               if (lo == 1) begin
                  r.noisy = 1'b1;
                  r.hit = HIT_LOWER;
               end else if (up == 3) begin
                  r.noisy = 1'b1;
                  r.hit = HIT_UPPER;
               end
            end
         end
         r.ratio = q[20:0];
         r.sum = p[21:0];
         r.not_pos = (p <= 0);
         pending.insert(pending.size(), r);
      endfunction

      function void check_response(r45_result_type got);
         r45_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (got.noisy !== e.noisy)
            $display("%0t: noisy expected %b actual %b", $time, e.noisy, got.noisy);
         if (got.hit !== e.hit)
            $display("%0t: limit_hit expected %0d actual %0d", $time, e.hit, got.hit);
         if (got.ratio !== e.ratio)
            $display("%0t: ratio expected %h actual %h", $time, e.ratio, got.ratio);
         if (got.sum !== e.sum)
            $display("%0t: sum_used expected %h actual %h", $time, e.sum, got.sum);
         if (got.not_pos !== e.not_pos)
            $display("%0t: sum_not_positive expected %b actual %b", $time, e.not_pos,
                     got.not_pos);
         if (got !== e) errors++;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic csr_we = 1'b0;
   logic [MIN_SUM_W-1:0] csr_wdata = '0;

   r45_scoreboard board = new();
   bit hold_off = 1'b0;
   int idle_cycles = 0;
   int sent = 0;

   r45_pulse_shape_noise_check_unit dut (.*);

   initial forever #1 clock = ~clock;

   // Compare each result transaction as it is accepted.
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response({rsp_tuser[0], rsp_tuser[2:1], rsp_tdata[20:0],
                               rsp_tdata[42:21], rsp_tdata[43]});

   // Receiver stall pattern, with a long hold-off on request.
   always @(posedge clock) begin
      if (hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 3) != 0) || (sent < 40) || (sent > 560);
   end

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || hold_off)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("tb_r45_pulse_shape_noise_check_unit failed");
         $finish;
      end
   end

   task automatic send_item(input logic box, input logic [20:0] c4, input logic [20:0] c5);
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, c5, c4};
      req_tuser <= box;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(box, c4, c5);
      sent++;
   endtask

   task automatic pause(input int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_floor(input logic [19:0] v);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      board.floor_val = v;
   endtask

   // Random charges: mostly realistic pulses, sometimes full-range values.
   task automatic random_item;
      logic [20:0] c4, c5;
      int total, frac;
      if ($urandom_range(0, 4) == 0) begin
         c4 = 21'($urandom);
         c5 = 21'($urandom);
      end else begin
         total = $urandom_range(0, 80000) - 2000;
         frac = $urandom_range(0, 1000);
         c4 = 21'(total * frac / 1000);
         c5 = 21'(total - total * frac / 1000);
         if ($urandom_range(0, 9) == 0) c5 = -c4;
      end
      send_item(1'($urandom_range(0, 1)), c4, c5);
   endtask

   task automatic random_phase(input int n);
      int burst;
      while (n > 0) begin
         burst = $urandom_range(1, 20);
         for (int i = 0; i < burst && n > 0; i++, n--) random_item();
         if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 6));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, zero sum, negative sum, thresholds, both modes.
      send_item(1'b0, 21'h0fffff, 21'h0fffff);
      send_item(1'b0, 21'h100000, 21'h100000);
      send_item(1'b0, 21'h0fffff, 21'h100000);
      send_item(1'b0, 21'd5, -21'sd5);
      send_item(1'b0, -21'sd5, 21'd5);
      send_item(1'b0, 21'd0, 21'd0);
      send_item(1'b1, 21'd0, 21'd0);
      send_item(1'b0, -21'sd300, 21'd10);
      send_item(1'b1, -21'sd300, 21'd10);
      send_item(1'b0, 21'd1600, 21'd0);
      send_item(1'b0, 21'd1601, 21'd0);
      send_item(1'b1, 21'd1120, 21'd0);
      send_item(1'b0, 21'd0, 21'd1920);
      send_item(1'b1, 21'd100, 21'd2300);
      send_item(1'b0, 21'd64000, 21'd0);
      send_item(1'b1, 21'd70000, 21'd1000);
      send_item(1'b0, 21'd30000, 21'd40000);
      send_item(1'b1, 21'd3000, 21'd3000);
      send_item(1'b0, 21'd1, 21'd0);
      drain();

      write_floor(20'd0);
      send_item(1'b1, 21'd0, 21'd0);
      send_item(1'b1, 21'd7, -21'sd7);
      random_phase(150);
      drain();

      write_floor(20'hfffff);
      random_phase(100);
      drain();

      write_floor(20'd1600);
      // Long receiver hold-off while the sender keeps offering items.
      fork
         begin
            hold_off = 1'b1;
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end
         random_phase(60);
      join
      drain();

      write_floor(20'd16);
      random_phase(300);
      drain();

      $display("Covered %0d requests over four floor settings in both modes, %0d results checked.",
               sent, board.checked);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("tb_r45_pulse_shape_noise_check_unit passed");
      else
         $display("tb_r45_pulse_shape_noise_check_unit failed");
      $finish;
   end
endmodule
